### design/akx_pkg.sv
`default_nettype none

package akx_pkg;

    // Mixing constants of the keystream
    localparam logic [63:0] SEED_MIX = 64'hafcb8f2ff4fff33f;
    localparam logic [63:0] STEP_MIX = 64'hfcbfaff8f2f4f3f0;

    // XOR of all 64 rotations of SEED_MIX: every bit equals its parity
    localparam logic [63:0] SEED_WRAP = {64{^SEED_MIX}};

    localparam int unsigned KEY_W   = 64;
    localparam int unsigned IDX_W   = 16;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CNT_W   = 6;

    // Operation codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEED,
        S_MUL,
        S_DIV
    } t_akx_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic seed_load;
        logic seed_step;
        logic out_load;
        logic mul_load;
        logic div_step;
    } t_akx_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic seed_last;
        logic div_last;
    } t_akx_sts;

endpackage

`default_nettype wire

### design/archive_keystream_xor.sv
`default_nettype none

// Keystream XOR for archive files. Write the 64-bit key on i_cfg_we/i_cfg_data
// while idle (a zero write is ignored; reset key is 1). A start word
// (operation 0) seeds the state from the key and file_index and gives no
// result; it keeps the block busy while the seeding rotate loop runs, one
// step per cycle. A data word (operation 1) returns
// data_byte XOR the low state byte and then advances the state; the block
// takes the next word only after one multiply step and a bit-serial
// remainder unit have run. The result sits in an output register, so a
// stalled consumer does not hold up the state update.
module archive_keystream_xor #(
    parameter int unsigned MAX_FILES = 65536
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [akx_pkg::KEY_W-1:0]  i_cfg_data,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic                       i_operation,
    input  wire logic [akx_pkg::IDX_W-1:0]  i_file_index,
    input  wire logic [akx_pkg::BYTE_W-1:0] i_data_byte,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic [akx_pkg::BYTE_W-1:0]      o_out_byte
);
    import akx_pkg::*;

    t_akx_cmd cmd;
    t_akx_sts sts;

    // Sequence the seeding and the state update
    akx_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Key, state, multiplier and remainder unit
    akx_dp #(
        .MAX_FILES (MAX_FILES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_file_index (i_file_index),
        .i_data_byte  (i_data_byte),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_out_byte   (o_out_byte)
    );

endmodule

`default_nettype wire

### design/akx_ctrl.sv
`default_nettype none

module akx_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_operation,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    input  wire akx_pkg::t_akx_sts i_sts,
    output akx_pkg::t_akx_cmd      o_cmd
);
    import akx_pkg::*;

    t_akx_state r_state;
    t_akx_state n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       accept;

    // Take a word only when idle and the result slot is free or draining
    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_operation == OP_DATA) ? S_MUL : S_SEED;
                end
            end
            S_SEED: begin
                if (i_sts.seed_last) begin
                    n_state = S_IDLE;
                end
            end
            S_MUL: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd           = '0;
        o_cmd.seed_load = accept && (i_operation == OP_START);
        o_cmd.out_load  = accept && (i_operation == OP_DATA);
        unique case (r_state)
            S_IDLE: begin
            end
            S_SEED: begin
                o_cmd.seed_step = !i_sts.seed_last;
            end
            S_MUL: begin
                o_cmd.mul_load = 1'b1;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Hold the result valid until taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

### design/akx_dp.sv
`default_nettype none

module akx_dp #(
    parameter int unsigned MAX_FILES = 65536
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [akx_pkg::KEY_W-1:0]      i_cfg_data,
    input  wire logic [akx_pkg::IDX_W-1:0]      i_file_index,
    input  wire logic [akx_pkg::BYTE_W-1:0]     i_data_byte,
    input  wire akx_pkg::t_akx_cmd              i_cmd,
    output akx_pkg::t_akx_sts                   o_sts,
    output logic [akx_pkg::BYTE_W-1:0]          o_out_byte
);
    import akx_pkg::*;

    localparam logic [IDX_W-1:0] IDX_LIMIT = IDX_W'(MAX_FILES - 1);

    logic [KEY_W-1:0]  r_key;
    logic [KEY_W-1:0]  r_state;
    logic [KEY_W-1:0]  r_acc;
    logic [KEY_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_cnt;
    logic [BYTE_W-1:0] r_out_byte;

    logic [IDX_W-1:0]  idx_cl;
    logic [KEY_W-1:0]  seed_base;
    logic [KEY_W-1:0]  seed_next;
    logic [71:0]       prod;
    logic [KEY_W:0]    rem_sh;
    logic [KEY_W:0]    rem_diff;
    logic [KEY_W-1:0]  rem_next;

    // Clamp the file index to the last valid file
    assign idx_cl = (i_file_index > IDX_LIMIT) ? IDX_LIMIT : i_file_index;

    // Whole turns of 64 steps fold into one XOR with the wrap constant
    assign seed_base = r_key ^ (idx_cl[CNT_W] ? SEED_WRAP : '0);

    // One seeding step: mix then rotate left by one
    always_comb begin
        seed_next = r_state ^ SEED_MIX;
        seed_next = {seed_next[KEY_W-2:0], seed_next[KEY_W-1]};
    end

    // Multiplier byte times state; the byte shift that zeroes the low byte comes when the dividend is loaded
    assign prod = 72'(r_key[15:8]) * 72'(r_state);

    // One restoring division step, remainder only
    assign rem_sh   = {r_rem, r_acc[KEY_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_key};
    assign rem_next = rem_diff[KEY_W] ? rem_sh[KEY_W-1:0] : rem_diff[KEY_W-1:0];

    assign o_sts.seed_last = (r_cnt == '0);
    assign o_sts.div_last  = (r_cnt == '0);
    assign o_out_byte      = r_out_byte;

    // Key register; drop writes of zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= KEY_W'(1);
        end else if (i_cfg_we && (i_cfg_data != '0)) begin
            r_key <= i_cfg_data;
        end
    end

    // Keystream state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_cmd.seed_load) begin
            r_state <= seed_base;
        end else if (i_cmd.seed_step) begin
            r_state <= seed_next;
        end else if (i_cmd.div_step && (r_cnt == '0)) begin
            r_state <= rem_next ^ STEP_MIX;
        end
    end

    // Step counter, dividend shifter and remainder
    always_ff @(posedge i_clk) begin
        if (i_cmd.seed_load) begin
            r_cnt <= idx_cl[CNT_W-1:0];
        end else if (i_cmd.seed_step) begin
            r_cnt <= r_cnt - 1'b1;
        end else if (i_cmd.mul_load) begin
            r_cnt <= '1;
            r_acc <= {prod[KEY_W-9:0], r_key[7:0]};
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt - 1'b1;
            r_acc <= {r_acc[KEY_W-2:0], 1'b0};
            r_rem <= rem_next;
        end
    end

    // Result byte from the current state
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_byte <= i_data_byte ^ r_state[BYTE_W-1:0];
        end
    end

endmodule

`default_nettype wire

### design/akx_checker.sv
`default_nettype none

module akx_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       o_in_ready,
    input wire logic                       i_operation,
    input wire logic                       o_out_valid,
    input wire logic                       i_out_ready,
    input wire logic [akx_pkg::BYTE_W-1:0] o_out_byte
);
    import akx_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && o_in_ready;

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_byte)))
        else $error("result word changed while stalled");

    // A data word yields a result word on the next cycle
    a_data_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_operation == OP_DATA)) |=> o_out_valid)
        else $error("data word gave no result");

    // A start word yields no result
    a_start_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_operation == OP_START) && !o_out_valid) |=> !o_out_valid)
        else $error("start word gave a result");

    // Block is busy right after any accepted word
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("word accepted while busy");

endmodule

bind archive_keystream_xor akx_checker u_akx_checker (.*);

`default_nettype wire

### sim/tb_top.sv
`default_nettype none

module tb_top;

    import akx_pkg::*;

    localparam int unsigned SETTLE_CYCLES  = 80;
    localparam int unsigned TAIL_CYCLES    = 100;
    localparam int unsigned WATCHDOG_LIMIT = 5000;

    localparam logic [63:0] KS_SEED_MIX  = 64'hafcb8f2ff4fff33f;
    localparam logic [63:0] KS_STEP_MIX  = 64'hfcbfaff8f2f4f3f0;
    localparam logic [63:0] KS_MULT_MASK = 64'h0000_0000_0000_ff00;
    localparam logic [63:0] KS_INC_MASK  = 64'h0000_0000_0000_00ff;

    typedef struct packed {
        logic              op;
        logic [IDX_W-1:0]  file_index;
        logic [BYTE_W-1:0] plain;
    } t_file_word;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [KEY_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic operation = 1'b0;
    logic [IDX_W-1:0] file_index = '0;
    logic [BYTE_W-1:0] data_byte = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [BYTE_W-1:0] out_byte;

    // Keystream shadow of the block
    logic [KEY_W-1:0] ks_key = 64'h1;
    logic [KEY_W-1:0] ks_state = '0;

    t_file_word pending_words[$];
    logic [BYTE_W-1:0] expected_bytes[$];

    bit failed = 1'b0;
    bit tx_noisy = 1'b1;
    bit rx_noisy = 1'b1;
    int unsigned tx_gap = 0;
    int unsigned rx_stall = 0;
    int unsigned idle_cycles = 0;

    archive_keystream_xor dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_operation  (operation),
        .i_file_index (file_index),
        .i_data_byte  (data_byte),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_out_byte   (out_byte)
    );

    always #6 clk = ~clk;

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    // Seed: load the key, then mix and rotate once per file index step
    function automatic void seed_keystream(logic [IDX_W-1:0] idx);
        logic [63:0] s;
        int unsigned n;
        s = ks_key;
        for (n = 0; n < idx; n++) begin
            s ^= KS_SEED_MIX;
            s = {s[62:0], s[63]};
        end
        ks_state = s;
    endfunction

    // Advance: multiply-add wrapped to 64 bits, reduce by the key, mix
    function automatic void advance_keystream();
        logic [63:0] t;
        t = (ks_key & KS_MULT_MASK) * ks_state + (ks_key & KS_INC_MASK);
        t = t % ks_key;
        ks_state = t ^ KS_STEP_MIX;
    endfunction

    function automatic void push_word(logic op, logic [IDX_W-1:0] idx,
                                      logic [BYTE_W-1:0] b);
        t_file_word w;
        w.op = op;
        w.file_index = idx;
        w.plain = b;
        pending_words.push_back(w);
    endfunction

    function automatic logic [IDX_W-1:0] pick_index();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return IDX_W'($urandom_range(0, 130));
        if (r < 75) return IDX_W'($urandom_range(0, 65535));
        if (r < 85)
            return IDX_W'({$urandom_range(0, 1023), 6'd0} + $urandom_range(0, 2) - 1);
        case ($urandom_range(0, 4))
            0: return 16'd0;
            1: return 16'd63;
            2: return 16'd64;
            3: return 16'd65534;
            default: return 16'd65535;
        endcase
    endfunction

    // Mostly a start followed by a run of data words, some loose words
    function automatic void queue_random(int unsigned count);
        int unsigned n;
        int unsigned run;
        int unsigned k;
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 9) < 7) begin
                push_word(OP_START, pick_index(), BYTE_W'($urandom_range(0, 255)));
                run = $urandom_range(1, 24);
                for (k = 0; k < run; k++)
                    push_word(OP_DATA, IDX_W'($urandom_range(0, 65535)),
                              BYTE_W'($urandom_range(0, 255)));
                n += run + 1;
            end else if ($urandom_range(0, 1) == 0) begin
                push_word(OP_DATA, IDX_W'($urandom_range(0, 65535)),
                          BYTE_W'($urandom_range(0, 255)));
                n += 1;
            end else begin
                push_word(OP_START, pick_index(), BYTE_W'($urandom_range(0, 255)));
                push_word(OP_START, pick_index(), BYTE_W'($urandom_range(0, 255)));
                n += 2;
            end
        end
    endfunction

    // Hold the caller until every word is in and every result is out
    task automatic drain();
        while (pending_words.size() != 0 || in_valid || expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_key(input logic [KEY_W-1:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        // A zero key is dropped by the block
        if (v != '0) ks_key = v;
    endtask

    task automatic random_phase(input logic [KEY_W-1:0] key, input int unsigned count);
        write_key(key);
        tx_noisy = ($urandom_range(0, 3) != 0);
        rx_noisy = ($urandom_range(0, 3) != 0);
        queue_random(count);
        drain();
    endtask

    // Send words from the pending queue
    always @(posedge clk) begin : drive_words
        t_file_word w;
        if (!rst_n) begin
            in_valid <= 1'b0;
            tx_gap <= 0;
        end else if (!in_valid || in_ready) begin
            if (tx_gap != 0) begin
                in_valid <= 1'b0;
                tx_gap <= tx_gap - 1;
            end else if (pending_words.size() != 0) begin
                w = pending_words.pop_front();
                in_valid <= 1'b1;
                operation <= w.op;
                file_index <= w.file_index;
                data_byte <= w.plain;
                tx_gap <= tx_noisy ? pick_gap() : 0;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Stall the result side at random
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            rx_stall <= 0;
        end else if (rx_stall != 0) begin
            out_ready <= 1'b0;
            rx_stall <= rx_stall - 1;
        end else begin
            out_ready <= 1'b1;
            if (rx_noisy && $urandom_range(0, 4) == 0) rx_stall <= pick_gap();
        end
    end

    // Check results, then predict from accepted words
    always @(posedge clk) begin : check_words
        logic [BYTE_W-1:0] want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_bytes.size() == 0) begin
                    $error("out_byte: result with no expectation, actual %h", out_byte);
                    failed = 1'b1;
                end else begin
                    want = expected_bytes.pop_front();
                    if (out_byte !== want) begin
                        $error("out_byte: expected %h, actual %h", want, out_byte);
                        failed = 1'b1;
                    end
                end
            end
            if (in_valid && in_ready) begin
                if (operation == OP_START) begin
                    seed_keystream(file_index);
                end else begin
                    expected_bytes.push_back(data_byte ^ ks_state[BYTE_W-1:0]);
                    advance_keystream();
                end
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[archive_keystream_xor] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset key: data before any start, extreme indexes and bytes
        tx_noisy = 1'b0;
        rx_noisy = 1'b0;
        push_word(OP_DATA,  16'hffff, 8'h00);
        push_word(OP_DATA,  16'h0000, 8'hff);
        push_word(OP_START, 16'd0,    8'hff);
        push_word(OP_DATA,  16'hffff, 8'hff);
        push_word(OP_DATA,  16'h1234, 8'h00);
        push_word(OP_START, 16'd65535, 8'h00);
        push_word(OP_DATA,  16'h0000, 8'ha5);
        push_word(OP_START, 16'd63,   8'h00);
        push_word(OP_DATA,  16'h0000, 8'h5a);
        push_word(OP_START, 16'd64,   8'h00);
        push_word(OP_DATA,  16'h0000, 8'h3c);
        push_word(OP_START, 16'd1,    8'h00);
        push_word(OP_START, 16'd2,    8'h00);
        push_word(OP_DATA,  16'h0000, 8'hc3);
        push_word(OP_DATA,  16'h0000, 8'h96);
        drain();

        // Zero key write must leave the key alone
        write_key('0);
        push_word(OP_START, 16'd5, 8'h00);
        push_word(OP_DATA,  16'h0000, 8'h11);
        push_word(OP_DATA,  16'h0000, 8'hee);
        drain();

        random_phase(64'hffff_ffff_ffff_ffff, 140);
        random_phase(64'h8000_0000_0000_0000, 140);
        random_phase(64'h0000_0000_0000_00ff, 130);
        random_phase(64'h0000_0000_0000_ff00, 130);
        random_phase(64'h1, 120);
        random_phase({$urandom, $urandom}, 150);
        random_phase({$urandom, $urandom}, 150);
        random_phase(64'($urandom_range(2, 300)), 150);
        random_phase({$urandom, $urandom} | 64'h1, 150);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_bytes.size() != 0) begin
            $error("out_byte: %0d expected words never arrived", expected_bytes.size());
            failed = 1'b1;
        end
        if (!failed)
            $display("[archive_keystream_xor] OK");
        else
            $display("[archive_keystream_xor] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
